// ===== hw/rtl/sfu_pkg.sv =====
// Shared types and constants for the starfield slot update block.
// Used by sfu_alu and starfield_slot_update_core; depends on nothing else.
package sfu_pkg;

    // Field widths of the beats and the table entries.
    localparam int COL_W    = 11;
    localparam int ROW_W    = 10;
    localparam int SIZE_W   = 3;
    localparam int CNT_W    = 7;
    localparam int IDX_O_W  = 6;
    localparam int REG_W    = 10;

    // Default table size and register reset values.
    localparam int SLOTS_DEF = 64;
    localparam logic [REG_W-1:0] SCREEN_WIDTH_RST = 10'd144;

    // Configuration register indexes.
    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    // One table entry as held in the slot memory.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SIZE_W-1:0] size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result of updating one slot, handed from the update unit to the sequencer.
    typedef struct packed {
        logic   vis;      // slot holds a star after this tick
        logic   spawned;  // the pending spawn went into this slot
        logic   hidden;   // a visible star left the screen
        logic   write;    // entry must be written back
        t_entry entry;    // entry after this tick
    } t_upd;

    // Slot walk sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PROC
    } t_state;

endpackage

// ===== hw/rtl/sfu_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Standalone; holds the starfield slot table.
module sfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sfu_alu.sv =====
// Shared slot update unit: two adds and one compare, used once per slot.
// Depends on sfu_pkg.
module sfu_alu
    import sfu_pkg::*;
(
    input  t_entry            i_entry,
    input  logic              i_vis,
    input  logic              i_spawn_pend,
    input  logic [ROW_W-1:0]  i_spawn_row,
    input  logic [SIZE_W-1:0] i_spawn_size,
    input  logic [REG_W-1:0]  i_width,
    output t_upd              o_upd
);

    logic [SIZE_W-1:0] w_size;
    logic [COL_W-1:0]  w_col;
    logic [COL_W-1:0]  w_limit;
    logic              w_spawn;
    logic              w_leave;

    // A free slot takes the pending spawn; it then starts at column zero.
    assign w_spawn = !i_vis && i_spawn_pend;
    assign w_size  = w_spawn ? ((i_spawn_size == '0) ? SIZE_W'(1) : i_spawn_size)
                             : i_entry.size;
    assign w_col   = w_spawn ? '0 : i_entry.col;

    // A star leaves once its column reaches width plus size.
    assign w_limit = COL_W'(i_width) + COL_W'(w_size);
    assign w_leave = w_col >= w_limit;

    always_comb begin
        o_upd             = '0;
        o_upd.entry.col   = '0;
        o_upd.entry.row   = '0;
        o_upd.entry.size  = SIZE_W'(1);
        if (i_vis || w_spawn) begin
            if (w_leave) begin
                o_upd.hidden = 1'b1;
            end else begin
                o_upd.vis        = 1'b1;
                o_upd.write      = 1'b1;
                o_upd.spawned    = w_spawn;
                o_upd.entry.col  = w_col + COL_W'(w_size);
                o_upd.entry.row  = w_spawn ? i_spawn_row : i_entry.row;
                o_upd.entry.size = w_size;
            end
        end
    end

endmodule

// ===== hw/rtl/starfield_slot_update_core.sv =====
// Top level of the starfield slot update block: sequencer, state and output stage.
// Depends on sfu_pkg, sfu_ram and sfu_alu.
//
// Usage:
// One input beat (spawn_row, spawn_size) is one frame tick. The block spawns
// a star into the lowest free slot if the table is not full, moves or hides
// every visible star, and sends one output beat per slot, slot 0 first, with
// last_record set on slot SLOTS-1. Hidden slots read column 0, row 0, size 1.
// Each slot is handled in two states: ST_READ reads its entry from the slot
// memory, and ST_PROC updates it, writes it back and loads the output
// register. A tick occupies the block until its last slot is committed, and
// the next input beat is taken only once the sequencer is back in ST_IDLE.
// The input stall is high while a tick is in work.
// When the receiver stalls, the walk holds on the current slot until the
// output register frees. Reset clears all visible marks and the star count
// at once, so no clearing pass is needed; screen width returns to 144.
// The user writes screen width through the configuration port only while idle;
// the block does not enforce this. Screen height is accepted but has no effect.
module starfield_slot_update_core
    import sfu_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [REG_W-1:0]   i_cfg_data,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ROW_W-1:0]   i_spawn_row,
    input  logic [SIZE_W-1:0]  i_spawn_size,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [IDX_O_W-1:0] o_slot_index,
    output logic               o_star_visible,
    output logic [COL_W-1:0]   o_star_column,
    output logic [ROW_W-1:0]   o_star_row,
    output logic [SIZE_W-1:0]  o_star_size,
    output logic               o_last_record
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [SLOTS-1:0]  r_vis;
    logic [CNT_W-1:0]  r_count;
    logic [REG_W-1:0]  r_width;
    logic              r_pend;
    logic [ROW_W-1:0]  r_spawn_row;
    logic [SIZE_W-1:0] r_spawn_size;
    logic              r_out_valid;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_rd_en;
    logic              w_commit;
    logic              w_last;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry            w_entry;
    t_upd              w_upd;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = r_idx == IDX_W'(SLOTS - 1);
    assign w_entry    = t_entry'(w_rdata);

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= SCREEN_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SCREEN_WIDTH:  r_width <= i_cfg_data;
                REG_SCREEN_HEIGHT: ;
                default:           ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_READ;
            end
            ST_READ: n_state = ST_PROC;
            ST_PROC: begin
                if (w_out_free) n_state = w_last ? ST_IDLE : ST_READ;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = 1'b1;
        w_rd_en    = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_READ: w_rd_en    = 1'b1;
            ST_PROC: w_commit   = w_out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Slot table memory, one entry per slot.
    sfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_commit && w_upd.write),
        .i_waddr (r_idx),
        .i_wdata (w_upd.entry),
        .i_re    (w_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Shared update unit.
    sfu_alu u_alu (
        .i_entry      (w_entry),
        .i_vis        (r_vis[r_idx]),
        .i_spawn_pend (r_pend),
        .i_spawn_row  (r_spawn_row),
        .i_spawn_size (r_spawn_size),
        .i_width      (r_width),
        .o_upd        (w_upd)
    );

    // Spawn request captured with the input beat.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_spawn_row  <= i_spawn_row;
            r_spawn_size <= i_spawn_size;
        end
    end

    // Slot pointer, visible marks, star count and pending spawn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_vis   <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else if (w_in_acc) begin
            r_idx  <= '0;
            r_pend <= r_count < CNT_W'(SLOTS);
        end else if (w_commit) begin
            r_vis[r_idx] <= w_upd.vis;
            if (!w_last) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (w_upd.spawned) begin
                r_pend <= 1'b0;
            end
            if (w_upd.spawned && !w_upd.hidden) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_upd.hidden) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            o_slot_index   <= IDX_O_W'(r_idx);
            o_star_visible <= w_upd.vis;
            o_star_column  <= w_upd.entry.col;
            o_star_row     <= w_upd.entry.row;
            o_star_size    <= w_upd.entry.size;
            o_last_record  <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    // The star count never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("star count above table size");

    // Between ticks the star count matches the visible marks.
    a_count_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> $countones(r_vis) == 32'(r_count))
        else $error("star count does not match visible marks");

    // The last record always describes the final slot.
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_record) |-> o_slot_index == IDX_O_W'(SLOTS - 1))
        else $error("last record on wrong slot");
`endif

endmodule
